FILE: rtl/tun_pkg.sv
// Shared constants and types for the triangle unit normal block.
// No dependencies; every other file of the block refers to this package.
`default_nettype none

package tun_pkg;

  // Default coordinate width of one vertex component (Q8.8).
  localparam int COORD_BITS_DEF = 16;

  // Number of normal components handled side by side.
  localparam int LANES = 3;

  // Bits of floor(2^30 * c^2 / s); the quotient never exceeds 2^30.
  localparam int QUO_BITS = 31;

  // Bits of the integer square root of that quotient (at most 2^15).
  localparam int ROOT_BITS = 16;

  // Width of one normal component on the result channel (Q2.14).
  localparam int OUT_BITS = 16;

  // Entries of the queue between the front and the back.
  localparam int Q_DEPTH = 4;

  // Queue status seen by the front and the back.
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

`default_nettype wire

FILE: rtl/tun_if.sv
// Channel interfaces of the triangle unit normal block: vertex words in,
// normal words out. Depends on tun_pkg.
`default_nettype none

interface tun_in_if #(
  parameter int COORD_BITS = tun_pkg::COORD_BITS_DEF
) ();
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] p0_x;
  logic signed [COORD_BITS-1:0] p0_y;
  logic signed [COORD_BITS-1:0] p0_z;
  logic signed [COORD_BITS-1:0] p1_x;
  logic signed [COORD_BITS-1:0] p1_y;
  logic signed [COORD_BITS-1:0] p1_z;
  logic signed [COORD_BITS-1:0] p2_x;
  logic signed [COORD_BITS-1:0] p2_y;
  logic signed [COORD_BITS-1:0] p2_z;

  modport source (
    output valid, p0_x, p0_y, p0_z, p1_x, p1_y, p1_z, p2_x, p2_y, p2_z,
    input  ready
  );
  modport sink (
    input  valid, p0_x, p0_y, p0_z, p1_x, p1_y, p1_z, p2_x, p2_y, p2_z,
    output ready
  );
endinterface

interface tun_out_if ();
  logic                                valid;
  logic                                ready;
  logic signed [tun_pkg::OUT_BITS-1:0] normal_x;
  logic signed [tun_pkg::OUT_BITS-1:0] normal_y;
  logic signed [tun_pkg::OUT_BITS-1:0] normal_z;
  logic                                degenerate;

  modport source (
    output valid, normal_x, normal_y, normal_z, degenerate,
    input  ready
  );
  modport sink (
    input  valid, normal_x, normal_y, normal_z, degenerate,
    output ready
  );
endinterface

`default_nettype wire

FILE: rtl/triangle_unit_normal.sv
// Throughput: one triangle per cycle while the queue has room and the result is being taken.
// The back moves whenever its output register is empty or being taken; the front whenever
// the four-entry queue between them is not full. Reset (rst_n, synchronous) clears valids
// and queue pointers and count only; the data registers are not reset.
// Top level of the triangle unit normal block. Depends on tun_pkg, tun_if,
// tun_front, tun_queue and tun_back.
`default_nettype none

module triangle_unit_normal #(
  parameter int COORD_BITS = tun_pkg::COORD_BITS_DEF
) (
  input  wire logic clk,
  input  wire logic rst_n,
  tun_in_if.sink    in_chan,
  tun_out_if.source out_chan
);

  // Working widths. The cross product is exact, its square is exact and the
  // squared length of the normal is the exact sum of the three squares.
  localparam int SQ = 4 * COORD_BITS + 2;
  localparam int SW = SQ + 2;
  localparam int L  = tun_pkg::LANES;
  localparam int QW = 1 + L + SW + L * SQ;

  // The front forms the edges a = p0 - p1 and b = p1 - p2, the cross product
  // a x b, the sign and square of each component, the squared length and
  // the degenerate flag (all three components zero).
  logic             push;
  logic [SQ-1:0]    f_sq [L];
  logic [SW-1:0]    f_s;
  logic [L-1:0]     f_neg;
  logic             f_deg;
  tun_pkg::q_stat_t q_stat;

  tun_front #(
    .COORD_BITS(COORD_BITS)
  ) u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_chan(in_chan),
    .q_full (q_stat.full),
    .push   (push),
    .sq_o   (f_sq),
    .s_o    (f_s),
    .neg_o  (f_neg),
    .deg_o  (f_deg)
  );

  // The queue lets the front keep accepting words while the result channel
  // is stalled, and lets the back drain while the input side is idle.
  logic [QW-1:0] q_wdata, q_rdata;
  logic          q_pop;

  assign q_wdata = {f_deg, f_neg, f_s, f_sq[2], f_sq[1], f_sq[0]};

  tun_queue #(
    .W(QW)
  ) u_queue (
    .clk  (clk),
    .rst_n(rst_n),
    .push (push),
    .wdata(q_wdata),
    .pop  (q_pop),
    .rdata(q_rdata),
    .stat (q_stat)
  );

  // The back computes each component as round(16384 * c / |c|) without any
  // rounding of the length: first the quotient floor(2^30 * c^2 / |c|^2),
  // then its integer square root t = floor(32768 * |c_i| / |c|), and finally
  // (t + 1) / 2, which rounds half away from zero. A degenerate triangle
  // yields the zero vector with the flag set.
  logic [SQ-1:0] b_sq [L];
  logic [SW-1:0] b_s;
  logic [L-1:0]  b_neg;
  logic          b_deg;

  always_comb begin
    for (int l = 0; l < L; l++) begin
      b_sq[l] = q_rdata[l*SQ +: SQ];
    end
    b_s   = q_rdata[L*SQ +: SW];
    b_neg = q_rdata[L*SQ+SW +: L];
    b_deg = q_rdata[QW-1];
  end

  tun_back #(
    .COORD_BITS(COORD_BITS)
  ) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (!q_stat.empty),
    .q_sq    (b_sq),
    .q_s     (b_s),
    .q_neg   (b_neg),
    .q_deg   (b_deg),
    .q_pop   (q_pop),
    .out_chan(out_chan)
  );

endmodule

`default_nettype wire

FILE: rtl/tun_front.sv
// Front pipeline: edges, exact cross product, squares and squared length.
// Depends on tun_pkg and tun_in_if.
`default_nettype none

module tun_front #(
  parameter int COORD_BITS = tun_pkg::COORD_BITS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  tun_in_if.sink                  in_chan,
  input  wire logic               q_full,
  output logic                    push,
  output logic [4*COORD_BITS+1:0] sq_o [tun_pkg::LANES],
  output logic [4*COORD_BITS+3:0] s_o,
  output logic [tun_pkg::LANES-1:0] neg_o,
  output logic                    deg_o
);

  localparam int EW = COORD_BITS + 1;     // edge, signed
  localparam int PW = 2 * COORD_BITS + 2; // product and cross term, signed
  localparam int MB = 2 * COORD_BITS + 1; // cross magnitude
  localparam int H  = COORD_BITS + 1;     // low split of the magnitude
  localparam int HI = MB - H;             // high split of the magnitude
  localparam int SQ = 2 * MB;
  localparam int SW = SQ + 2;
  localparam int NS = 7;
  localparam int L  = tun_pkg::LANES;

  logic en;
  logic vld_r [NS];

  logic signed [EW-1:0] a_r [L];
  logic signed [EW-1:0] b_r [L];
  logic signed [PW-1:0] pp_r [L];
  logic signed [PW-1:0] pq_r [L];
  logic signed [PW-1:0] c_r [L];
  logic [MB-1:0]        mag_r [L];
  logic [2*H-1:0]       ll_r [L];
  logic [H+HI-1:0]      lh_r [L];
  logic [2*HI-1:0]      hh_r [L];
  logic [SQ-1:0]        sq6_r [L];
  logic [SQ-1:0]        sq7_r [L];
  logic [SW-1:0]        s_r;
  logic [L-1:0]         neg4_r, neg5_r, neg6_r, neg7_r;
  logic                 deg4_r, deg5_r, deg6_r, deg7_r;

  // The whole front moves together; it holds while the queue is full.
  assign en            = !q_full;
  assign in_chan.ready = en;
  assign push          = en && vld_r[NS-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NS; i++) begin
        vld_r[i] <= 1'b0;
      end
    end else if (en) begin
      vld_r[0] <= in_chan.valid;
      for (int i = 1; i < NS; i++) begin
        vld_r[i] <= vld_r[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_r[0] <= EW'(in_chan.p0_x) - EW'(in_chan.p1_x);
      a_r[1] <= EW'(in_chan.p0_y) - EW'(in_chan.p1_y);
      a_r[2] <= EW'(in_chan.p0_z) - EW'(in_chan.p1_z);
      b_r[0] <= EW'(in_chan.p1_x) - EW'(in_chan.p2_x);
      b_r[1] <= EW'(in_chan.p1_y) - EW'(in_chan.p2_y);
      b_r[2] <= EW'(in_chan.p1_z) - EW'(in_chan.p2_z);

      pp_r[0] <= a_r[1] * b_r[2];
      pq_r[0] <= a_r[2] * b_r[1];
      pp_r[1] <= a_r[2] * b_r[0];
      pq_r[1] <= a_r[0] * b_r[2];
      pp_r[2] <= a_r[0] * b_r[1];
      pq_r[2] <= a_r[1] * b_r[0];

      for (int i = 0; i < L; i++) begin
        c_r[i]   <= pp_r[i] - pq_r[i];
        neg4_r[i] <= c_r[i][PW-1];
        mag_r[i] <= c_r[i][PW-1] ? MB'(-c_r[i]) : MB'(c_r[i]);
        ll_r[i]  <= mag_r[i][H-1:0] * mag_r[i][H-1:0];
        lh_r[i]  <= mag_r[i][H-1:0] * mag_r[i][MB-1:H];
        hh_r[i]  <= mag_r[i][MB-1:H] * mag_r[i][MB-1:H];
        sq6_r[i] <= (SQ'(hh_r[i]) << (2 * H)) + (SQ'(lh_r[i]) << (H + 1))
                    + SQ'(ll_r[i]);
        sq7_r[i] <= sq6_r[i];
      end
      deg4_r <= (c_r[0] == '0) && (c_r[1] == '0) && (c_r[2] == '0);

      neg5_r <= neg4_r;
      neg6_r <= neg5_r;
      neg7_r <= neg6_r;
      deg5_r <= deg4_r;
      deg6_r <= deg5_r;
      deg7_r <= deg6_r;

      s_r <= SW'(sq6_r[0]) + SW'(sq6_r[1]) + SW'(sq6_r[2]);
    end
  end

  assign sq_o  = sq7_r;
  assign s_o   = s_r;
  assign neg_o = neg7_r;
  assign deg_o = deg7_r;

endmodule

`default_nettype wire

FILE: rtl/tun_queue.sv
// Short register queue that decouples the front from the back.
// Depends on tun_pkg.
`default_nettype none

module tun_queue #(
  parameter int W = 8
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         push,
  input  wire logic [W-1:0] wdata,
  input  wire logic         pop,
  output logic [W-1:0]      rdata,
  output tun_pkg::q_stat_t  stat
);

  localparam int D  = tun_pkg::Q_DEPTH;
  localparam int AW = $clog2(D);

  logic [W-1:0]  mem_r [D];
  logic [AW-1:0] wr_r, rd_r;
  logic [AW:0]   cnt_r;

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wr_r <= wr_r + 1'b1;
      end
      if (pop) begin
        rd_r <= rd_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  assign rdata      = mem_r[rd_r];
  assign stat.full  = (cnt_r == (AW + 1)'(D));
  assign stat.empty = (cnt_r == '0);

endmodule

`default_nettype wire

FILE: rtl/tun_back.sv
// Back pipeline: restoring divide of 2^30*c^2 by the squared length, integer
// square root, rounding and sign. Depends on tun_pkg and tun_out_if.
`default_nettype none

module tun_back #(
  parameter int COORD_BITS = tun_pkg::COORD_BITS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 q_valid,
  input  wire logic [4*COORD_BITS+1:0] q_sq [tun_pkg::LANES],
  input  wire logic [4*COORD_BITS+3:0] q_s,
  input  wire logic [tun_pkg::LANES-1:0] q_neg,
  input  wire logic                 q_deg,
  output logic                      q_pop,
  tun_out_if.source                 out_chan
);

  localparam int SQ  = 4 * COORD_BITS + 2;
  localparam int SW  = SQ + 2;
  localparam int RW  = SW + 1;
  localparam int QB  = tun_pkg::QUO_BITS;
  localparam int NB  = tun_pkg::ROOT_BITS;
  localparam int SRW = QB + 2;
  localparam int OW  = tun_pkg::OUT_BITS;
  localparam int L   = tun_pkg::LANES;

  logic en;
  logic out_vld_r;
  logic signed [OW-1:0] nrm_r [L];
  logic deg_out_r;

  logic [RW-1:0]  drem_r [QB][L];
  logic [QB-1:0]  dquo_r [QB][L];
  logic [SW-1:0]  ds_r   [QB];
  logic [L-1:0]   dneg_r [QB];
  logic           ddeg_r [QB];
  logic           dvld_r [QB];

  logic [SRW-1:0] srem_r [NB][L];
  logic [NB-1:0]  sres_r [NB][L];
  logic [L-1:0]   sneg_r [NB];
  logic           sdeg_r [NB];
  logic           svld_r [NB];

  assign en    = !out_vld_r || out_chan.ready;
  assign q_pop = en && q_valid;

  // One quotient bit per stage, most significant first.
  for (genvar k = 0; k < QB; k++) begin : g_div
    logic [RW-1:0] rin [L];
    logic [QB-1:0] qin [L];
    logic [SW-1:0] sin;
    logic [L-1:0]  nin;
    logic          din;
    logic          vin;

    if (k == 0) begin : g_first
      always_comb begin
        for (int l = 0; l < L; l++) begin
          rin[l] = RW'(q_sq[l]);
          qin[l] = '0;
        end
        sin = q_s;
        nin = q_neg;
        din = q_deg;
        vin = q_valid;
      end
    end else begin : g_next
      always_comb begin
        for (int l = 0; l < L; l++) begin
          rin[l] = {drem_r[k-1][l][RW-2:0], 1'b0};
          qin[l] = dquo_r[k-1][l];
        end
        sin = ds_r[k-1];
        nin = dneg_r[k-1];
        din = ddeg_r[k-1];
        vin = dvld_r[k-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        for (int l = 0; l < L; l++) begin
          if (rin[l] >= {1'b0, sin}) begin
            drem_r[k][l] <= rin[l] - {1'b0, sin};
            dquo_r[k][l] <= qin[l] | (QB'(1) << (QB - 1 - k));
          end else begin
            drem_r[k][l] <= rin[l];
            dquo_r[k][l] <= qin[l];
          end
        end
        ds_r[k]   <= sin;
        dneg_r[k] <= nin;
        ddeg_r[k] <= din;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dvld_r[k] <= 1'b0;
      end else if (en) begin
        dvld_r[k] <= vin;
      end
    end
  end

  // One root bit per stage; the remainder tracks r - root^2.
  for (genvar j = 0; j < NB; j++) begin : g_sqrt
    localparam int B = NB - 1 - j;
    logic [SRW-1:0] rin [L];
    logic [NB-1:0]  qin [L];
    logic [SRW-1:0] d   [L];
    logic [L-1:0]   nin;
    logic           din;
    logic           vin;

    if (j == 0) begin : g_first
      always_comb begin
        for (int l = 0; l < L; l++) begin
          rin[l] = SRW'(dquo_r[QB-1][l]);
          qin[l] = '0;
        end
        nin = dneg_r[QB-1];
        din = ddeg_r[QB-1];
        vin = dvld_r[QB-1];
      end
    end else begin : g_next
      always_comb begin
        for (int l = 0; l < L; l++) begin
          rin[l] = srem_r[j-1][l];
          qin[l] = sres_r[j-1][l];
        end
        nin = sneg_r[j-1];
        din = sdeg_r[j-1];
        vin = svld_r[j-1];
      end
    end

    always_comb begin
      for (int l = 0; l < L; l++) begin
        d[l] = (SRW'(qin[l]) << (B + 1)) + (SRW'(1) << (2 * B));
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        for (int l = 0; l < L; l++) begin
          if (d[l] <= rin[l]) begin
            srem_r[j][l] <= rin[l] - d[l];
            sres_r[j][l] <= qin[l] | (NB'(1) << B);
          end else begin
            srem_r[j][l] <= rin[l];
            sres_r[j][l] <= qin[l];
          end
        end
        sneg_r[j] <= nin;
        sdeg_r[j] <= din;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        svld_r[j] <= 1'b0;
      end else if (en) begin
        svld_r[j] <= vin;
      end
    end
  end

  // Round half away from zero: m = (floor(2*|n|) + 1) / 2, then apply sign.
  always_ff @(posedge clk) begin
    if (en) begin
      for (int l = 0; l < L; l++) begin
        logic [NB:0]   inc;
        logic [OW-1:0] m;
        inc = {1'b0, sres_r[NB-1][l]} + (NB + 1)'(1);
        m   = OW'(inc[NB:1]);
        if (sdeg_r[NB-1]) begin
          nrm_r[l] <= '0;
        end else if (sneg_r[NB-1][l]) begin
          nrm_r[l] <= -$signed(m);
        end else begin
          nrm_r[l] <= $signed(m);
        end
      end
      deg_out_r <= sdeg_r[NB-1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (en) begin
      out_vld_r <= svld_r[NB-1];
    end
  end

  assign out_chan.valid      = out_vld_r;
  assign out_chan.normal_x   = nrm_r[0];
  assign out_chan.normal_y   = nrm_r[1];
  assign out_chan.normal_z   = nrm_r[2];
  assign out_chan.degenerate = deg_out_r;

endmodule

`default_nettype wire
